// File: rtl/core/i2c_master_byte_sequencer_unit_defines.svh
// Assertion macros shared by the I2C byte sequencer checkers.
`ifndef I2C_MASTER_BYTE_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CMBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CMBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/i2cmbs_pkg.sv
// Shared types and constants of the I2C master byte sequencer.
`default_nettype none
package i2cmbs_pkg;

    // Command codes carried in the request mode field
    localparam logic [2:0] MODE_TICK     = 3'd0;
    localparam logic [2:0] MODE_START    = 3'd1;
    localparam logic [2:0] MODE_STOP     = 3'd2;
    localparam logic [2:0] MODE_WRITE    = 3'd3;
    localparam logic [2:0] MODE_WAIT_ACK = 3'd4;
    localparam logic [2:0] MODE_READ     = 3'd5;

    // Configuration register indexes
    localparam logic REG_TICKS_PER_US  = 1'b0;
    localparam logic REG_ACK_TIMEOUT   = 1'b1;

    // Configuration reset values
    localparam logic [15:0] TICKS_PER_US_RST = 16'd100;
    localparam logic [7:0]  ACK_TIMEOUT_RST  = 8'd250;

    // Bits per transferred byte
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Delay lengths in microsecond units
    localparam logic [2:0] UNITS_START_STOP = 3'd4;
    localparam logic [2:0] UNITS_TWO        = 3'd2;
    localparam logic [2:0] UNITS_ONE        = 3'd1;

    // One result of the sequencer
    typedef struct packed {
        logic       ack_failed;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/core/i2c_master_byte_sequencer_unit.sv
// Each result is registered, or parked in the skid while the master side stalls.
// Throughput: one request per cycle while the skid is empty; the sequencer state
// advances once per request. A two-entry output stage (result register plus skid)
// keeps intake going while the master side stalls, until the skid fills.
// Reset (aresetn low, synchronous): lines idle high and driven, phase idle,
// configuration back to 100 ticks per microsecond and 250 ACK polls.
`default_nettype none
module i2c_master_byte_sequencer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    // Request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9], zero fill
    input  wire logic [2:0]  s_tuser,   // mode[2:0]
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // scl_level[0], sda_level[1], sda_drive[2],
                                        // busy_res[3], done_res[4], rx_byte[12:5],
                                        // ack_failed[13], zero fill
);

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    i2cmbs_pkg::result_t out_data_reg, out_data_next;
    i2cmbs_pkg::result_t skid_data_reg, skid_data_next;
    i2cmbs_pkg::result_t result;
    logic                accept;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    i2cmbs_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .advance   (accept),
        .mode      (s_tuser),
        .tx_byte   (s_tdata[7:0]),
        .send_ack  (s_tdata[8]),
        .sda_in    (s_tdata[9]),
        .result    (result)
    );

    // Route the new result to the output register or park it in the skid
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = accept;
                out_data_next  = result;
            end
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    // Hold valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

endmodule
`default_nettype wire

// File: rtl/core/i2cmbs_seq.sv
// Bit-level sequencer: line state, delay counting and command phases.
`default_nettype none
module i2cmbs_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic                cfg_addr,
    input  wire logic [15:0]         cfg_wdata,
    input  wire logic                advance,
    input  wire logic [2:0]          mode,
    input  wire logic [7:0]          tx_byte,
    input  wire logic                send_ack,
    input  wire logic                sda_in,
    output i2cmbs_pkg::result_t      result
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_WB_HIGH, PH_WB_LOW, PH_WB_NEXT,
        PH_WA1, PH_WA_POLL, PH_RB_HIGH, PH_RB_NEXT, PH_AK_HIGH, PH_AK_END
    } phase_t;

    logic [15:0] tpu_reg;
    logic [7:0]  timeout_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] delay_reg, delay_next;
    logic [2:0]  units_reg, units_next;
    logic [3:0]  bitcnt_reg, bitcnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  poll_reg, poll_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        drive_reg, drive_next;
    logic        ackc_reg, ackc_next;
    logic [7:0]  rx_reg, rx_next;
    logic        fail_reg, fail_next;
    logic        done;
    logic [15:0] delay_load;
    logic        waiting;

    // Reload value of the tick counter; a zero register acts as one tick
    assign delay_load = (tpu_reg == 16'd0) ? 16'd0 : tpu_reg - 16'd1;
    assign waiting    = (delay_reg != 16'd0) || (units_reg > 3'd1);

    // Next state for one tick
    always_comb begin
        phase_next  = phase_reg;
        delay_next  = delay_reg;
        units_next  = units_reg;
        bitcnt_next = bitcnt_reg;
        shift_next  = shift_reg;
        poll_next   = poll_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        drive_next  = drive_reg;
        ackc_next   = ackc_reg;
        rx_next     = rx_reg;
        fail_next   = fail_reg;
        done        = 1'b0;

        if (phase_reg == PH_IDLE) begin
            case (mode)
                i2cmbs_pkg::MODE_START: begin
                    drive_next = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    units_next = i2cmbs_pkg::UNITS_START_STOP;
                    delay_next = delay_load;
                    phase_next = PH_ST1;
                end
                i2cmbs_pkg::MODE_STOP: begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    units_next = i2cmbs_pkg::UNITS_START_STOP;
                    delay_next = delay_load;
                    phase_next = PH_SP1;
                end
                i2cmbs_pkg::MODE_WRITE: begin
                    drive_next  = 1'b1;
                    scl_next    = 1'b0;
                    bitcnt_next = 4'd0;
                    sda_next    = tx_byte[7];
                    shift_next  = {tx_byte[6:0], 1'b0};
                    units_next  = i2cmbs_pkg::UNITS_TWO;
                    delay_next  = delay_load;
                    phase_next  = PH_WB_HIGH;
                end
                i2cmbs_pkg::MODE_WAIT_ACK: begin
                    fail_next  = 1'b0;
                    poll_next  = 8'd0;
                    drive_next = 1'b0;
                    sda_next   = 1'b1;
                    units_next = i2cmbs_pkg::UNITS_ONE;
                    delay_next = delay_load;
                    phase_next = PH_WA1;
                end
                i2cmbs_pkg::MODE_READ: begin
                    ackc_next   = send_ack;
                    drive_next  = 1'b0;
                    scl_next    = 1'b0;
                    bitcnt_next = 4'd0;
                    shift_next  = 8'd0;
                    units_next  = i2cmbs_pkg::UNITS_TWO;
                    delay_next  = delay_load;
                    phase_next  = PH_RB_HIGH;
                end
                default: begin
                end
            endcase
        end else if (waiting) begin
            // Count down ticks, then units
            if (delay_reg != 16'd0) begin
                delay_next = delay_reg - 16'd1;
            end else begin
                units_next = units_reg - 3'd1;
                delay_next = delay_load;
            end
        end else begin
            case (phase_reg)
                PH_ST1: begin
                    sda_next   = 1'b0;
                    units_next = i2cmbs_pkg::UNITS_START_STOP;
                    delay_next = delay_load;
                    phase_next = PH_ST2;
                end
                PH_ST2: begin
                    scl_next = 1'b0;
                    done     = 1'b1;
                end
                PH_SP1: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    units_next = i2cmbs_pkg::UNITS_START_STOP;
                    delay_next = delay_load;
                    phase_next = PH_SP2;
                end
                PH_SP2: begin
                    done = 1'b1;
                end
                PH_WB_HIGH: begin
                    scl_next   = 1'b1;
                    units_next = i2cmbs_pkg::UNITS_TWO;
                    delay_next = delay_load;
                    phase_next = PH_WB_LOW;
                end
                PH_WB_LOW: begin
                    scl_next    = 1'b0;
                    bitcnt_next = bitcnt_reg + 4'd1;
                    units_next  = i2cmbs_pkg::UNITS_TWO;
                    delay_next  = delay_load;
                    phase_next  = PH_WB_NEXT;
                end
                PH_WB_NEXT: begin
                    if (bitcnt_reg >= i2cmbs_pkg::BITS_PER_BYTE) begin
                        done = 1'b1;
                    end else begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        units_next = i2cmbs_pkg::UNITS_TWO;
                        delay_next = delay_load;
                        phase_next = PH_WB_HIGH;
                    end
                end
                PH_WA1: begin
                    scl_next   = 1'b1;
                    units_next = i2cmbs_pkg::UNITS_ONE;
                    delay_next = delay_load;
                    phase_next = PH_WA_POLL;
                end
                PH_WA_POLL: begin
                    // Poll SDA every tick; too many high polls end in a stop
                    units_next = 3'd0;
                    delay_next = 16'd0;
                    if (!sda_in) begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end else if (poll_reg >= timeout_reg) begin
                        fail_next  = 1'b1;
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        units_next = i2cmbs_pkg::UNITS_START_STOP;
                        delay_next = delay_load;
                        phase_next = PH_SP1;
                    end else begin
                        poll_next = poll_reg + 8'd1;
                    end
                end
                PH_RB_HIGH: begin
                    scl_next    = 1'b1;
                    shift_next  = {shift_reg[6:0], sda_in};
                    bitcnt_next = bitcnt_reg + 4'd1;
                    units_next  = i2cmbs_pkg::UNITS_ONE;
                    delay_next  = delay_load;
                    phase_next  = PH_RB_NEXT;
                end
                PH_RB_NEXT: begin
                    scl_next   = 1'b0;
                    units_next = i2cmbs_pkg::UNITS_TWO;
                    delay_next = delay_load;
                    if (bitcnt_reg >= i2cmbs_pkg::BITS_PER_BYTE) begin
                        drive_next = 1'b1;
                        sda_next   = ~ackc_reg;
                        phase_next = PH_AK_HIGH;
                    end else begin
                        phase_next = PH_RB_HIGH;
                    end
                end
                PH_AK_HIGH: begin
                    scl_next   = 1'b1;
                    units_next = i2cmbs_pkg::UNITS_TWO;
                    delay_next = delay_load;
                    phase_next = PH_AK_END;
                end
                PH_AK_END: begin
                    scl_next = 1'b0;
                    rx_next  = shift_reg;
                    done     = 1'b1;
                end
                default: begin
                    done = 1'b1;
                end
            endcase
            // Drop back to idle on completion
            if (done) begin
                phase_next = PH_IDLE;
                units_next = 3'd0;
                delay_next = 16'd0;
            end
        end
    end

    // Result of this tick: line levels and flags after the update
    always_comb begin
        result.scl_level  = scl_next;
        result.sda_level  = sda_next;
        result.sda_drive  = drive_next;
        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = done;
        result.rx_byte    = rx_next;
        result.ack_failed = fail_next;
    end

    // Hold configuration, phase and line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg     <= i2cmbs_pkg::TICKS_PER_US_RST;
            timeout_reg <= i2cmbs_pkg::ACK_TIMEOUT_RST;
            phase_reg   <= PH_IDLE;
            delay_reg   <= 16'd0;
            units_reg   <= 3'd0;
            bitcnt_reg  <= 4'd0;
            shift_reg   <= 8'd0;
            poll_reg    <= 8'd0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            drive_reg   <= 1'b1;
            ackc_reg    <= 1'b0;
            rx_reg      <= 8'd0;
            fail_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == i2cmbs_pkg::REG_TICKS_PER_US) begin
                    tpu_reg <= cfg_wdata;
                end else begin
                    timeout_reg <= cfg_wdata[7:0];
                end
            end
            if (advance) begin
                phase_reg  <= phase_next;
                delay_reg  <= delay_next;
                units_reg  <= units_next;
                bitcnt_reg <= bitcnt_next;
                shift_reg  <= shift_next;
                poll_reg   <= poll_next;
                scl_reg    <= scl_next;
                sda_reg    <= sda_next;
                drive_reg  <= drive_next;
                ackc_reg   <= ackc_next;
                rx_reg     <= rx_next;
                fail_reg   <= fail_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/i2cmbs_checker.sv
// Port-level checker for the I2C master byte sequencer, bound to the top level.
`default_nettype none
`include "i2c_master_byte_sequencer_unit_defines.svh"
module i2cmbs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // A stalled result holds
    `I2CMBS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // Intake only closes while a result is waiting
    `I2CMBS_ASSERT_IMPLY(a_ready_backpressure, aclk, aresetn, !s_tready, m_tvalid, "request refused with no result pending")

    // A completing tick never reports busy
    `I2CMBS_ASSERT_IMPLY(a_done_not_busy, aclk, aresetn, m_tvalid && m_tdata[4], !m_tdata[3], "done and busy in one result")

endmodule

bind i2c_master_byte_sequencer_unit i2cmbs_checker u_i2cmbs_checker (.*);
`default_nettype wire

// File: test/tb_top.sv
// Self-checking stream testbench for the I2C master byte sequencer.
`timescale 1ns / 1ps
module tb_top;

    // Mode values outside the command set; the sequencer treats them as plain ticks
    localparam logic [2:0] MODE_RSVD_6 = 3'd6;
    localparam logic [2:0] MODE_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } line_req_t;

    typedef enum logic [4:0] {
        SQ_IDLE, SQ_START_A, SQ_START_B, SQ_STOP_A, SQ_STOP_B,
        SQ_WR_HIGH, SQ_WR_LOW, SQ_WR_NEXT, SQ_ACK_SETUP, SQ_ACK_POLL,
        SQ_RD_HIGH, SQ_RD_NEXT, SQ_ANS_HIGH, SQ_ANS_END
    } seq_state_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;

    line_req_t           req_q[$];
    i2cmbs_pkg::result_t line_exp_q[$];
    int unsigned err_count     = 0;
    int unsigned results_seen  = 0;
    int unsigned gen_items     = 0;
    int unsigned cmds_finished = 0;
    logic [3:0]  send_gap      = '0;
    int unsigned recv_stall    = 0;
    bit          send_burst    = 1'b0;
    bit          recv_burst    = 1'b0;

    // Predicted sequencer state and configuration
    logic [15:0] tick_unit;
    logic [7:0]  poll_limit;
    seq_state_t  sq_state;
    logic [15:0] wait_cnt;
    logic [2:0]  units_rem;
    logic [3:0]  bits_done;
    logic [7:0]  shreg;
    logic [7:0]  polls;
    logic        scl_q, sda_q, drv_q, ack_sel, fail_q;
    logic [7:0]  rx_last;

    i2c_master_byte_sequencer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin : clk_gen
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin : rst_gen
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin : watchdog
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void reset_pred();
        tick_unit  = i2cmbs_pkg::TICKS_PER_US_RST;
        poll_limit = i2cmbs_pkg::ACK_TIMEOUT_RST;
        sq_state   = SQ_IDLE;
        wait_cnt   = '0;
        units_rem  = '0;
        bits_done  = '0;
        shreg      = '0;
        polls      = '0;
        scl_q      = 1'b1;
        sda_q      = 1'b1;
        drv_q      = 1'b1;
        ack_sel    = 1'b0;
        rx_last    = '0;
        fail_q     = 1'b0;
    endfunction

    // Load a delay of the given number of units; a zero tick register counts as one
    function automatic void arm_delay(input logic [2:0] units);
        logic [15:0] t;
        t = (tick_unit != 16'd0) ? tick_unit : 16'd1;
        units_rem = units;
        wait_cnt  = t - 16'd1;
    endfunction

    function automatic void enter_stop();
        drv_q = 1'b1;
        scl_q = 1'b0;
        sda_q = 1'b0;
        arm_delay(i2cmbs_pkg::UNITS_START_STOP);
        sq_state = SQ_STOP_A;
    endfunction

    function automatic void shift_out_bit();
        sda_q = shreg[7];
        shreg = {shreg[6:0], 1'b0};
        arm_delay(i2cmbs_pkg::UNITS_TWO);
        sq_state = SQ_WR_HIGH;
    endfunction

    // Advance the predicted sequencer by one tick and return the line levels after it
    function automatic i2cmbs_pkg::result_t step_lines(input line_req_t rq);
        logic                fin;
        i2cmbs_pkg::result_t r;
        fin = 1'b0;
        if (sq_state == SQ_IDLE) begin
            case (rq.mode)
                i2cmbs_pkg::MODE_START: begin
                    drv_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
                    arm_delay(i2cmbs_pkg::UNITS_START_STOP);
                    sq_state = SQ_START_A;
                end
                i2cmbs_pkg::MODE_STOP: enter_stop();
                i2cmbs_pkg::MODE_WRITE: begin
                    drv_q = 1'b1; scl_q = 1'b0;
                    shreg = rq.tx_byte;
                    bits_done = '0;
                    shift_out_bit();
                end
                i2cmbs_pkg::MODE_WAIT_ACK: begin
                    fail_q = 1'b0; polls = '0;
                    drv_q = 1'b0; sda_q = 1'b1;
                    arm_delay(i2cmbs_pkg::UNITS_ONE);
                    sq_state = SQ_ACK_SETUP;
                end
                i2cmbs_pkg::MODE_READ: begin
                    ack_sel = rq.send_ack;
                    drv_q = 1'b0; scl_q = 1'b0;
                    bits_done = '0; shreg = '0;
                    arm_delay(i2cmbs_pkg::UNITS_TWO);
                    sq_state = SQ_RD_HIGH;
                end
                default: ;
            endcase
        end else if (wait_cnt != 16'd0 || units_rem > 3'd1) begin
            // count down the current delay unit, then the remaining units
            if (wait_cnt != 16'd0) begin
                wait_cnt = wait_cnt - 16'd1;
            end else begin
                units_rem = units_rem - 3'd1;
                arm_delay(units_rem);
            end
        end else begin
            case (sq_state)
                SQ_START_A: begin
                    sda_q = 1'b0; arm_delay(i2cmbs_pkg::UNITS_START_STOP);
                    sq_state = SQ_START_B;
                end
                SQ_START_B: begin
                    scl_q = 1'b0; fin = 1'b1;
                end
                SQ_STOP_A: begin
                    scl_q = 1'b1; sda_q = 1'b1;
                    arm_delay(i2cmbs_pkg::UNITS_START_STOP); sq_state = SQ_STOP_B;
                end
                SQ_STOP_B: fin = 1'b1;
                SQ_WR_HIGH: begin
                    scl_q = 1'b1; arm_delay(i2cmbs_pkg::UNITS_TWO); sq_state = SQ_WR_LOW;
                end
                SQ_WR_LOW: begin
                    scl_q = 1'b0; bits_done = bits_done + 4'd1;
                    arm_delay(i2cmbs_pkg::UNITS_TWO); sq_state = SQ_WR_NEXT;
                end
                SQ_WR_NEXT: begin
                    if (bits_done >= i2cmbs_pkg::BITS_PER_BYTE) fin = 1'b1;
                    else shift_out_bit();
                end
                SQ_ACK_SETUP: begin
                    scl_q = 1'b1; arm_delay(i2cmbs_pkg::UNITS_ONE); sq_state = SQ_ACK_POLL;
                end
                SQ_ACK_POLL: begin
                    // poll every tick; low SDA is the ACK
                    units_rem = '0; wait_cnt = '0;
                    if (rq.sda_in == 1'b0) begin
                        scl_q = 1'b0; fin = 1'b1;
                    end else if (polls >= poll_limit) begin
                        fail_q = 1'b1;
                        enter_stop();
                    end else begin
                        polls = polls + 8'd1;
                    end
                end
                SQ_RD_HIGH: begin
                    scl_q = 1'b1;
                    shreg = {shreg[6:0], rq.sda_in};
                    bits_done = bits_done + 4'd1;
                    arm_delay(i2cmbs_pkg::UNITS_ONE); sq_state = SQ_RD_NEXT;
                end
                SQ_RD_NEXT: begin
                    scl_q = 1'b0;
                    if (bits_done >= i2cmbs_pkg::BITS_PER_BYTE) begin
                        drv_q = 1'b1;
                        sda_q = ~ack_sel;
                        arm_delay(i2cmbs_pkg::UNITS_TWO); sq_state = SQ_ANS_HIGH;
                    end else begin
                        arm_delay(i2cmbs_pkg::UNITS_TWO); sq_state = SQ_RD_HIGH;
                    end
                end
                SQ_ANS_HIGH: begin
                    scl_q = 1'b1; arm_delay(i2cmbs_pkg::UNITS_TWO); sq_state = SQ_ANS_END;
                end
                SQ_ANS_END: begin
                    scl_q = 1'b0; rx_last = shreg; fin = 1'b1;
                end
                default: fin = 1'b1;
            endcase
            if (fin) begin
                sq_state = SQ_IDLE;
                units_rem = '0;
                wait_cnt = '0;
            end
        end
        r.scl_level  = scl_q;
        r.sda_level  = sda_q;
        r.sda_drive  = drv_q;
        r.busy_res   = (sq_state != SQ_IDLE);
        r.done_res   = fin;
        r.rx_byte    = rx_last;
        r.ack_failed = fail_q;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    // Queue one tick request together with its predicted result
    task automatic push_req(input logic [2:0] mode, input logic [7:0] tx, input logic ack,
                            input logic sda);
        line_req_t           rq;
        i2cmbs_pkg::result_t r;
        rq.mode     = mode;
        rq.tx_byte  = tx;
        rq.send_ack = ack;
        rq.sda_in   = sda;
        r = step_lines(rq);
        if (r.done_res) cmds_finished++;
        gen_items++;
        req_q.push_back(rq);
        line_exp_q.push_back(r);
    endtask

    // Issue one command and tick until the sequencer is idle again; the slave holds
    // SDA high for hi_polls ACK polls, then pulls it low
    task automatic run_cmd(input logic [2:0] mode, input logic [7:0] tx, input logic ack,
                           input int unsigned hi_polls);
        int unsigned hi_given;
        logic        sda;
        hi_given = 0;
        push_req(mode, tx, ack, 1'($urandom));
        while (sq_state != SQ_IDLE) begin
            sda = 1'($urandom);
            if (sq_state == SQ_ACK_POLL && wait_cnt == 16'd0 && units_rem <= 3'd1) begin
                sda = (hi_given < hi_polls);
                if (sda) hi_given++;
            end
            // mode and data are ignored while busy, so send noise there
            push_req(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), sda);
        end
    endtask

    task automatic idle_ticks(input int unsigned n);
        int unsigned pick;
        repeat (n) begin
            pick = $urandom_range(0, 2);
            push_req((pick == 0) ? i2cmbs_pkg::MODE_TICK
                                 : ((pick == 1) ? MODE_RSVD_6 : MODE_RSVD_7),
                     8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic random_cmd();
        int unsigned pick;
        int unsigned hi;
        pick = $urandom_range(0, 99);
        hi   = $urandom_range(0, 3);
        // land right at the poll limit or one past it now and then
        if ($urandom_range(0, 4) == 0) hi = 32'(poll_limit) + $urandom_range(0, 1);
        if (pick < 30)      run_cmd(i2cmbs_pkg::MODE_WRITE, 8'($urandom), 1'($urandom), hi);
        else if (pick < 55) run_cmd(i2cmbs_pkg::MODE_READ, 8'($urandom), 1'($urandom), hi);
        else if (pick < 75) run_cmd(i2cmbs_pkg::MODE_WAIT_ACK, 8'($urandom), 1'($urandom), hi);
        else if (pick < 85) run_cmd(i2cmbs_pkg::MODE_START, 8'($urandom), 1'($urandom), hi);
        else if (pick < 95) run_cmd(i2cmbs_pkg::MODE_STOP, 8'($urandom), 1'($urandom), hi);
        else                idle_ticks(1);
        idle_ticks($urandom_range(0, 3));
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || s_tvalid || line_exp_q.size() != 0) @(posedge aclk);
    endtask

    // Write both registers once the sequencer has gone quiet
    task automatic write_cfg(input logic [15:0] ticks, input logic [7:0] limit);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= i2cmbs_pkg::REG_TICKS_PER_US;
        cfg_wdata <= ticks;
        @(posedge aclk);
        cfg_addr  <= i2cmbs_pkg::REG_ACK_TIMEOUT;
        cfg_wdata <= {8'h00, limit};
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        tick_unit  = ticks;
        poll_limit = limit;
    endtask

    initial begin : stimulus
        int unsigned round_items;
        int unsigned round_done;
        logic [15:0] ticks;
        logic [7:0]  limit;
        reset_pred();
        while (aresetn !== 1'b1) @(posedge aclk);

        // Reset configuration: full-length ACK wait answered on the first poll
        run_cmd(i2cmbs_pkg::MODE_WAIT_ACK, 8'h00, 1'b0, 0);

        // Fastest timing, zero timeout: bytes 0xFF and 0xA5, ACK, failing ACK, both answers
        write_cfg(16'd1, 8'd0);
        run_cmd(i2cmbs_pkg::MODE_WRITE, 8'hFF, 1'b1, 0);
        run_cmd(i2cmbs_pkg::MODE_WRITE, 8'hA5, 1'b0, 0);
        run_cmd(i2cmbs_pkg::MODE_WAIT_ACK, 8'h00, 1'b0, 0);
        run_cmd(i2cmbs_pkg::MODE_WAIT_ACK, 8'h00, 1'b0, 1);
        run_cmd(i2cmbs_pkg::MODE_READ, 8'h00, 1'b1, 0);
        run_cmd(i2cmbs_pkg::MODE_READ, 8'hFF, 1'b0, 0);
        run_cmd(i2cmbs_pkg::MODE_START, 8'h00, 1'b0, 0);
        run_cmd(i2cmbs_pkg::MODE_STOP, 8'h00, 1'b0, 0);
        run_cmd(MODE_RSVD_6, 8'h00, 1'b0, 0);
        run_cmd(MODE_RSVD_7, 8'hFF, 1'b1, 0);
        run_cmd(i2cmbs_pkg::MODE_TICK, 8'h00, 1'b0, 0);

        // Zero tick register acts as one; timeout after a single tolerated high poll
        write_cfg(16'd0, 8'd1);
        run_cmd(i2cmbs_pkg::MODE_WAIT_ACK, 8'h00, 1'b0, 1);
        run_cmd(i2cmbs_pkg::MODE_WAIT_ACK, 8'h00, 1'b0, 2);
        run_cmd(i2cmbs_pkg::MODE_WRITE, 8'($urandom), 1'b0, 0);
        run_cmd(i2cmbs_pkg::MODE_READ, 8'h00, 1'($urandom), 0);

        // Register maxima; commands would run far too long here, so tick only
        write_cfg(16'hFFFF, 8'hFF);
        idle_ticks(20);

        // Random rounds at one and two ticks per unit
        for (int round = 0; round < 2; round++) begin
            ticks = (round == 0) ? 16'd1 : 16'd2;
            limit = 8'($urandom_range(1, 6));
            write_cfg(ticks, limit);
            round_items = gen_items;
            round_done  = cmds_finished;
            while ((gen_items - round_items < 60 || cmds_finished - round_done < 3)
                   && gen_items - round_items < 400)
                random_cmd();
        end

        // Drain and let the output stage settle
        wait_drained();
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // ---------------------------------------------------------------- driver

    // Present queued requests, then hold off a random number of cycles after each
    always @(posedge aclk) begin : req_driver
        line_req_t rq;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap != 4'd0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 4'd1;
            end else if (req_q.size() != 0) begin
                rq = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'd0, rq.sda_in, rq.send_ack, rq.tx_byte};
                s_tuser  <= rq.mode;
                if ($urandom_range(0, 49) == 0) send_burst = ~send_burst;
                send_gap <= send_burst ? 4'd0 : 4'($urandom_range(0, 9));
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        err_count++;
        $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                 results_seen, what, got, want);
    endtask

    task automatic cmp_field(input string what, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) report_mismatch(what, 16'(got), 16'(want));
    endtask

    // Check each accepted result against the oldest prediction, then stall at random
    always @(posedge aclk) begin : res_monitor
        i2cmbs_pkg::result_t got;
        i2cmbs_pkg::result_t want;
        int unsigned         k;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end else if (m_tvalid && m_tready) begin
            got = m_tdata[13:0];
            if (line_exp_q.size() == 0) begin
                report_mismatch("result with no request pending", m_tdata, 16'd0);
            end else begin
                want = line_exp_q.pop_front();
                cmp_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
                cmp_field("sda_level", 8'(got.sda_level), 8'(want.sda_level));
                cmp_field("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
                cmp_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                cmp_field("done_res", 8'(got.done_res), 8'(want.done_res));
                cmp_field("rx_byte", got.rx_byte, want.rx_byte);
                cmp_field("ack_failed", 8'(got.ack_failed), 8'(want.ack_failed));
            end
            results_seen++;
            if ($urandom_range(0, 49) == 0) recv_burst = ~recv_burst;
            k = recv_burst ? 0 : $urandom_range(0, 9);
            m_tready   <= (k == 0);
            recv_stall <= k;
        end else if (recv_stall > 1) begin
            recv_stall <= recv_stall - 1;
        end else begin
            recv_stall <= 0;
            m_tready   <= 1'b1;
        end
    end

endmodule
